>>> src/rc4_pkg.sv
// Shared types and constants for the RC4 keystream cipher core.
// Used by the controller, the datapath and the top level; no dependencies.
package rc4_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 9;
	localparam int SBOX_DEPTH  = 256;
	localparam int SBOX_AW     = 8;
	localparam int KEY_DEPTH_DEF = 256;

	// Request type codes
	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;      // start of key schedule: identity S-box, j, k and key position cleared
		logic step_a;     // read S[a]
		logic step_b;     // read S[b], update j
		logic swap_a;     // write S[a] = S[b], read S[t]
		logic swap_b;     // write S[b] = old S[a]
		logic sched;      // running the key schedule
		logic load_out;   // load the output register
		logic load_held;  // load from held keystream byte
		logic key_wr;     // key-write item accepted
		logic data_take;  // data item accepted
	} rc4_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic k_last;     // last key schedule step
		logic out_full;   // output register holds an item
	} rc4_sts_t;

endpackage

>>> src/rc4_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write first in code order, read returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/rc4_ctrl.sv
// Controller state machine for the RC4 core: input handshake, key schedule
// sequencing and keystream step sequencing. Depends on rc4_pkg.
module rc4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic              message_start,
	input  logic              out_ready,
	input  rc4_pkg::rc4_sts_t sts,
	output rc4_pkg::rc4_cmd_t cmd
);
	import rc4_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_RD_A = 7'b0000100,
		S_RD_B = 7'b0001000,
		S_WR_A = 7'b0010000,
		S_WR_B = 7'b0100000,
		S_HOLD = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   sched_q, sched_d;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !sts.out_full || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		sched_d = sched_q;
		cmd     = '0;
		cmd.sched = sched_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_DATA) begin
						cmd.data_take = 1'b1;
						sched_d = message_start;
						state_d = message_start ? S_INIT : S_RD_A;
					end else begin
						cmd.key_wr = 1'b1;
					end
				end
			end
			S_INIT: begin
				cmd.clear = 1'b1;
				state_d   = S_RD_A;
			end
			S_RD_A: begin
				cmd.step_a = 1'b1;
				state_d    = S_RD_B;
			end
			S_RD_B: begin
				cmd.step_b = 1'b1;
				state_d    = S_WR_A;
			end
			S_WR_A: begin
				cmd.swap_a = 1'b1;
				state_d    = S_WR_B;
			end
			S_WR_B: begin
				cmd.swap_b = 1'b1;
				if (sched_q) begin
					// schedule step: next schedule step, or after the last one the keystream step of this item
					if (sts.k_last) begin
						sched_d = 1'b0;
					end
					state_d = S_RD_A;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					cmd.load_out  = 1'b1;
					cmd.load_held = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				sched_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sched_q <= sched_d;
		end
	end

	// Schedule flag never survives back to idle
	a_idle_no_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sched_q)
		else $error("key schedule flag set while idle");

	// Waiting for the output slot only while it is occupied
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> sts.out_full)
		else $error("holding a result with a free output register");

	// Data item without message start goes straight to the keystream step
	a_data_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_DATA && !message_start) |=> (state_q == S_RD_A))
		else $error("data item did not start a keystream step");

endmodule

>>> src/rc4_dp.sv
// Datapath for the RC4 core: S-box RAM with valid bits, key store RAM,
// indices, key length register and output register. Depends on rc4_pkg, rc4_ram.
module rc4_dp #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rc4_pkg::rc4_cmd_t         cmd,
	output rc4_pkg::rc4_sts_t         sts,
	input  logic                      cfg_valid,
	input  logic [rc4_pkg::LEN_W-1:0] cfg_data,
	input  logic [7:0]                key_index,
	input  logic [7:0]                key_byte,
	input  logic [7:0]                data_byte,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [7:0]                out_byte
);
	import rc4_pkg::*;

	localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(KEY_DEPTH);

	// Control registers
	logic [LEN_W-1:0]      key_length_q;
	logic [SBOX_DEPTH-1:0] vld_q;
	logic [BYTE_W-1:0]     i_q, j_q, k_q;
	logic [LEN_W-1:0]      kpos_q;
	logic                  out_valid_q;

	// Payload registers
	logic [BYTE_W-1:0]  a_q, b_q, sa_q, sb_q, t_q, ks_q, data_q, out_byte_q;
	logic [SBOX_AW-1:0] raddr_q;
	logic               vld_rd_q;

	logic [LEN_W-1:0]   len_eff, kpos_inc;
	logic [BYTE_W-1:0]  sval, key_rdata, kadd, a_next, b_next, t_next, ks;
	logic               sbox_re, sbox_we;
	logic [SBOX_AW-1:0] sbox_raddr, sbox_waddr;
	logic [BYTE_W-1:0]  sbox_wdata, sbox_rdata;
	logic               key_we, sched_end;

	// Effective key length: zero counts as one, saturate at the store depth
	always_comb begin
		if (key_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (key_length_q > DEPTH_LEN) begin
			len_eff = DEPTH_LEN;
		end else begin
			len_eff = key_length_q;
		end
	end
	assign kpos_inc = kpos_q + LEN_W'(1);

	// S-box read value; an entry not written since the last clear reads as its index
	assign sval   = vld_rd_q ? sbox_rdata : raddr_q;
	assign kadd   = cmd.sched ? key_rdata : '0;
	assign a_next = cmd.sched ? k_q : i_q + 8'd1;
	assign b_next = j_q + sval + kadd;
	assign t_next = sa_q + sval;

	// Keystream byte, with bypass for the entries just swapped
	always_comb begin
		if (t_q == a_q) begin
			ks = sb_q;
		end else if (t_q == b_q) begin
			ks = sa_q;
		end else begin
			ks = sval;
		end
	end

	// S-box port selection
	assign sbox_re = cmd.step_a || cmd.step_b || cmd.swap_a;
	always_comb begin
		case (1'b1)
			cmd.step_a: sbox_raddr = a_next;
			cmd.step_b: sbox_raddr = b_next;
			default:    sbox_raddr = t_next;
		endcase
	end
	assign sbox_we    = cmd.swap_a || cmd.swap_b;
	assign sbox_waddr = cmd.swap_a ? a_q : b_q;
	assign sbox_wdata = cmd.swap_a ? sval : sa_q;

	assign key_we    = cmd.key_wr && ({1'b0, key_index} < DEPTH_LEN);
	assign sched_end = cmd.swap_b && cmd.sched && sts.k_last;

	rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
		.clk   (clk),
		.we    (sbox_we),
		.waddr (sbox_waddr),
		.wdata (sbox_wdata),
		.re    (sbox_re),
		.raddr (sbox_raddr),
		.rdata (sbox_rdata)
	);

	rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_index[KEY_AW-1:0]),
		.wdata (key_byte),
		.re    (cmd.step_a && cmd.sched),
		.raddr (kpos_q[KEY_AW-1:0]),
		.rdata (key_rdata)
	);

	// Control state: key length, valid bits, indices, output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= LEN_W'(1);
			vld_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			kpos_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				key_length_q <= cfg_data;
			end
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (sbox_we) begin
				vld_q[sbox_waddr] <= 1'b1;
			end
			if (cmd.clear) begin
				k_q    <= '0;
				kpos_q <= '0;
				j_q    <= '0;
			end else if (cmd.step_b) begin
				j_q <= b_next;
			end else if (sched_end) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.swap_b && !cmd.sched) begin
				i_q <= a_q;
			end
			if (cmd.swap_b && cmd.sched) begin
				k_q    <= k_q + 8'd1;
				kpos_q <= (kpos_inc == len_eff) ? '0 : kpos_inc;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.data_take) begin
			data_q <= data_byte;
		end
		if (sbox_re) begin
			raddr_q  <= sbox_raddr;
			vld_rd_q <= vld_q[sbox_raddr];
		end
		if (cmd.step_a) begin
			a_q <= a_next;
		end
		if (cmd.step_b) begin
			b_q  <= b_next;
			sa_q <= sval;
		end
		if (cmd.swap_a) begin
			sb_q <= sval;
			t_q  <= t_next;
		end
		if (cmd.swap_b) begin
			ks_q <= ks;
		end
		if (cmd.load_out) begin
			out_byte_q <= data_q ^ (cmd.load_held ? ks_q : ks);
		end
	end

	assign sts.k_last   = (k_q == 8'hFF);
	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// Indices restart at zero once the key schedule finishes
	a_sched_end_idx: assert property (@(posedge clk) disable iff (!arst_n)
		sched_end |=> (i_q == '0 && j_q == '0))
		else $error("indices not cleared after key schedule");

	// Key position stays inside the store while the schedule runs
	a_kpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_a && cmd.sched) |-> (kpos_q < DEPTH_LEN))
		else $error("key position beyond key store");

endmodule

>>> src/rc4_keystream_cipher_core.sv
// RC4 core: a key-write item is written on acceptance; a data item takes 3 dependent S-box reads
// and 2 writes, and no new item is accepted until its result is loaded into the output register.
// Message start first runs the key schedule (a clear step, then one step per S-box entry).
// Output register: a result waits for out_ready while the next item is accepted.
// Reset (arst_n low, async): identity S-box via cleared valid bits, indices zero,
// key_length 1; key store contents undefined until written.
module rc4_keystream_cipher_core #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rc4_pkg::LEN_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic [7:0]                key_index,
	input  logic [7:0]                key_byte,
	input  logic [7:0]                data_byte,
	input  logic                      message_start,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte
);
	import rc4_pkg::*;

	rc4_cmd_t cmd;
	rc4_sts_t sts;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	rc4_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.message_start (message_start),
		.out_ready     (out_ready),
		.sts           (sts),
		.cmd           (cmd)
	);

	rc4_dp #(.KEY_DEPTH(KEY_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.key_index (key_index),
		.key_byte  (key_byte),
		.data_byte (data_byte),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte)
	);

endmodule
